// File: rtl/ubx_pkg.sv
// ----------------------------------------------------------------------------
// UBX receiver package
// Shared types, codes and constants of the binary frame receiver.
// ----------------------------------------------------------------------------
package ubx_pkg;

  // Largest payload length the design accepts, whatever max_payload holds.
  localparam int unsigned PAYLOAD_LIMIT = 256;

  // Field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 9;
  localparam int unsigned WIDE_LEN_W = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 9;

  // Limit as a 16-bit value for comparison with a received length.
  localparam logic [WIDE_LEN_W-1:0] PAYLOAD_LIMIT_W = WIDE_LEN_W'(PAYLOAD_LIMIT);

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h62;
  localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 9'd256;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_FIRST  = 2'd0,
    CFG_SYNC_SECOND = 2'd1,
    CFG_MAX_PAYLOAD = 2'd2
  } cfg_idx_t;

  // Event codes reported with every request.
  typedef enum logic [2:0] {
    EV_IDLE      = 3'd0,
    EV_SYNC_LOST = 3'd1,
    EV_PAYLOAD   = 3'd2,
    EV_CSUM_ERR  = 3'd3,
    EV_GOOD      = 3'd4,
    EV_TOO_LONG  = 3'd5
  } event_t;

  // Frame phases.
  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_IDENT   = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

  // A classified byte as it travels from the front to the back part.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_sync1;
    logic              is_sync2;
  } ubx_item_t;

endpackage

// File: rtl/ubx_ifs.sv
// ----------------------------------------------------------------------------
// UBX receiver channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------

// Received byte channel.
interface ubx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface ubx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  frame_class;
  logic [7:0]  frame_ident;
  logic [8:0]  frame_length;
  logic [7:0]  payload_value;
  logic [7:0]  payload_position;
  logic [31:0] sync_loss_total;
  logic [31:0] checksum_error_total;

  modport source (output valid, output event_res, output frame_class, output frame_ident,
                  output frame_length, output payload_value, output payload_position,
                  output sync_loss_total, output checksum_error_total, input ready);
  modport sink   (input valid, input event_res, input frame_class, input frame_ident,
                  input frame_length, input payload_value, input payload_position,
                  input sync_loss_total, input checksum_error_total, output ready);
endinterface

// Register write channel.
interface ubx_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ubx_frame_receiver.sv
// ----------------------------------------------------------------------------
// UBX frame receiver
// Byte-serial parser of binary GPS frames with Fletcher-8 checking.
// ----------------------------------------------------------------------------
// The receiver takes one byte per request and returns exactly one result
// request per byte: an event code, the current class, id and length, the
// payload byte with its index during the payload, and the running sync loss
// and checksum error counts. It sustains one byte per clock cycle while
// results are taken without stalling. A byte passes through the two-entry
// queue between the classifying front part and the frame state machine,
// which updates its state as it takes the byte from the queue and loads its
// result into the result register. A stalled result holds the state
// machine while the queue absorbs up to two further bytes. Register writes
// are always accepted and should be made only while no frame traffic is in
// flight.
module ubx_frame_receiver import ubx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ubx_in_if.sink    in_ch,
  ubx_out_if.source out_ch,
  ubx_cfg_if.sink   cfg_ch
);

  logic [BYTE_W-1:0] sync_first_r;
  logic [BYTE_W-1:0] sync_second_r;
  logic [LEN_W-1:0]  max_payload_r;

  logic      q_full;
  logic      q_push;
  ubx_item_t q_push_item;
  logic      q_pop;
  logic      q_valid;
  ubx_item_t q_pop_item;

  // Configuration registers; writes to unused indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_ch.data[BYTE_W-1:0];
        CFG_SYNC_SECOND: sync_second_r <= cfg_ch.data[BYTE_W-1:0];
        CFG_MAX_PAYLOAD: max_payload_r <= cfg_ch.data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front part: accept and classify.
  ubx_front u_front (
    .in_ch       (in_ch),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_push_item)
  );

  // Queue between the two parts.
  ubx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_pop_item)
  );

  // Back part: frame state machine and result register.
  ubx_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_payload (max_payload_r),
    .q_valid     (q_valid),
    .q_item      (q_pop_item),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// File: rtl/ubx_front.sv
// ----------------------------------------------------------------------------
// UBX receiver front part
// Accepts received bytes and tags them with their sync byte matches.
// ----------------------------------------------------------------------------
module ubx_front import ubx_pkg::*; (
  ubx_in_if.sink            in_ch,
  input  logic [BYTE_W-1:0] sync_first,
  input  logic [BYTE_W-1:0] sync_second,
  input  logic              q_full,
  output logic              q_push,
  output ubx_item_t         q_item
);

  // A byte is taken whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Classify the byte against both sync patterns.
  always_comb begin
    q_item.data     = in_ch.rx_byte;
    q_item.is_sync1 = (in_ch.rx_byte == sync_first);
    q_item.is_sync2 = (in_ch.rx_byte == sync_second);
  end

endmodule

// File: rtl/ubx_queue.sv
// ----------------------------------------------------------------------------
// UBX receiver queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module ubx_queue import ubx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ubx_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output ubx_item_t pop_item
);

  ubx_item_t         store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = store_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/ubx_back.sv
// ----------------------------------------------------------------------------
// UBX receiver back part
// Frame state machine, Fletcher-8 sums, counters and the result register.
// ----------------------------------------------------------------------------
module ubx_back import ubx_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] max_payload,
  input  logic             q_valid,
  input  ubx_item_t        q_item,
  output logic             q_pop,
  ubx_out_if.source        out_ch
);

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  class_r, class_nxt;
  logic [BYTE_W-1:0]  ident_r, ident_nxt;
  logic [BYTE_W-1:0]  sum_a_r, sum_a_nxt;
  logic [BYTE_W-1:0]  sum_b_r, sum_b_nxt;
  logic [LEN_W-1:0]   length_r, length_nxt;
  logic [LEN_W-1:0]   byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0]   sync_loss_r, sync_loss_nxt;
  logic [CNT_W-1:0]   csum_err_r, csum_err_nxt;

  event_t             ev_nxt;
  logic [BYTE_W-1:0]  pval_nxt;
  logic [BYTE_W-1:0]  ppos_nxt;

  logic               out_valid_r;
  event_t             out_event_r;
  logic [BYTE_W-1:0]  out_pval_r;
  logic [BYTE_W-1:0]  out_ppos_r;

  logic               fire;
  logic [BYTE_W-1:0]  b;
  logic [BYTE_W-1:0]  add_a;
  logic [BYTE_W-1:0]  add_b;
  logic [WIDE_LEN_W-1:0] full_len;
  logic [WIDE_LEN_W-1:0] limit;
  logic [LEN_W-1:0]   bc_inc;

  // A byte leaves the queue when the result register is free or being emptied.
  assign fire  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = fire;
  assign b     = q_item.data;

  // Fletcher-8 step and length arithmetic.
  assign add_a    = sum_a_r + b;
  assign add_b    = sum_b_r + add_a;
  assign full_len = {b, length_r[BYTE_W-1:0]};
  assign limit    = ({{(WIDE_LEN_W-LEN_W){1'b0}}, max_payload} < PAYLOAD_LIMIT_W) ?
                    {{(WIDE_LEN_W-LEN_W){1'b0}}, max_payload} : PAYLOAD_LIMIT_W;
  assign bc_inc   = byte_count_r + LEN_W'(1);

  // Next state and result of the byte at the head of the queue.
  always_comb begin
    phase_nxt      = phase_r;
    class_nxt      = class_r;
    ident_nxt      = ident_r;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    length_nxt     = length_r;
    byte_count_nxt = byte_count_r;
    sync_loss_nxt  = sync_loss_r;
    csum_err_nxt   = csum_err_r;
    ev_nxt         = EV_IDLE;
    pval_nxt       = '0;
    ppos_nxt       = '0;
    if (fire) begin
      unique case (phase_r)
        PH_SYNC2: begin
          if (!q_item.is_sync2) begin
            sync_loss_nxt = sync_loss_r + CNT_W'(1);
            ev_nxt        = EV_SYNC_LOST;
            phase_nxt     = PH_HUNT;
          end else begin
            phase_nxt = PH_CLASS;
          end
        end
        PH_CLASS: begin
          class_nxt = b;
          sum_a_nxt = b;
          sum_b_nxt = b;
          phase_nxt = PH_IDENT;
        end
        PH_IDENT: begin
          ident_nxt = b;
          sum_a_nxt = add_a;
          sum_b_nxt = add_b;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_nxt = {1'b0, b};
          sum_a_nxt  = add_a;
          sum_b_nxt  = add_b;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (full_len > limit) begin
            // Oversized length: saturate the stored length and resume hunting.
            length_nxt    = (|full_len[WIDE_LEN_W-1:LEN_W]) ? '1 : full_len[LEN_W-1:0];
            sync_loss_nxt = sync_loss_r + CNT_W'(1);
            ev_nxt        = EV_TOO_LONG;
            phase_nxt     = PH_HUNT;
          end else begin
            length_nxt     = full_len[LEN_W-1:0];
            sum_a_nxt      = add_a;
            sum_b_nxt      = add_b;
            byte_count_nxt = '0;
            phase_nxt      = (full_len[LEN_W-1:0] == '0) ? PH_CK_A : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt      = add_a;
          sum_b_nxt      = add_b;
          ev_nxt         = EV_PAYLOAD;
          pval_nxt       = b;
          ppos_nxt       = byte_count_r[BYTE_W-1:0];
          byte_count_nxt = bc_inc;
          if (bc_inc == length_r) begin
            phase_nxt = PH_CK_A;
          end
        end
        PH_CK_A: begin
          if (b != sum_a_r) begin
            csum_err_nxt = csum_err_r + CNT_W'(1);
            ev_nxt       = EV_CSUM_ERR;
            phase_nxt    = PH_HUNT;
          end else begin
            phase_nxt = PH_CK_B;
          end
        end
        PH_CK_B: begin
          phase_nxt = PH_HUNT;
          if (b != sum_b_r) begin
            csum_err_nxt = csum_err_r + CNT_W'(1);
            ev_nxt       = EV_CSUM_ERR;
          end else begin
            ev_nxt = EV_GOOD;
          end
        end
        default: begin
          // Hunting for the first sync byte; unused codes behave the same.
          if (!q_item.is_sync1) begin
            sync_loss_nxt = sync_loss_r + CNT_W'(1);
            ev_nxt        = EV_SYNC_LOST;
            phase_nxt     = PH_HUNT;
          end else begin
            phase_nxt = PH_SYNC2;
          end
        end
      endcase
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      class_r      <= '0;
      ident_r      <= '0;
      sum_a_r      <= '0;
      sum_b_r      <= '0;
      length_r     <= '0;
      byte_count_r <= '0;
      sync_loss_r  <= '0;
      csum_err_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      class_r      <= class_nxt;
      ident_r      <= ident_nxt;
      sum_a_r      <= sum_a_nxt;
      sum_b_r      <= sum_b_nxt;
      length_r     <= length_nxt;
      byte_count_r <= byte_count_nxt;
      sync_loss_r  <= sync_loss_nxt;
      csum_err_r   <= csum_err_nxt;
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register: per-byte fields.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_event_r <= ev_nxt;
      out_pval_r  <= pval_nxt;
      out_ppos_r  <= ppos_nxt;
    end
  end

  // The frame fields and counters of a result equal the state after its byte,
  // which the state registers hold until the next byte is taken.
  assign out_ch.valid                = out_valid_r;
  assign out_ch.event_res            = out_event_r;
  assign out_ch.frame_class          = class_r;
  assign out_ch.frame_ident          = ident_r;
  assign out_ch.frame_length         = length_r;
  assign out_ch.payload_value        = out_pval_r;
  assign out_ch.payload_position     = out_ppos_r;
  assign out_ch.sync_loss_total      = sync_loss_r;
  assign out_ch.checksum_error_total = csum_err_r;

  // The sync loss count moves only with a sync loss or oversized length event.
  a_sync_loss_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ev_nxt != EV_SYNC_LOST && ev_nxt != EV_TOO_LONG) |=>
      (sync_loss_r == $past(sync_loss_r)))
    else $error("sync loss count moved without a sync loss event");

  // A good frame is only reported on the second check byte.
  a_good_on_ck_b: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ev_nxt == EV_GOOD) |-> (phase_r == PH_CK_B))
    else $error("frame good reported outside the second check byte");

  // The payload index stays below the stored length.
  a_payload_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (byte_count_r < length_r))
    else $error("payload index reached the frame length");

  // A new byte is never taken while a result is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !fire)
    else $error("result register overwritten while stalled");

endmodule
